FILE: hdl/swr_pkg.sv
// shared constants and types for the sliding window range unit
`default_nettype none

package swr_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 7;
    localparam int RANGE_BITS      = 16;
    localparam int WINDOW_RESET    = 1;

    // membership of one stored sample in the two candidate lists
    typedef struct packed {
        logic max_mem;
        logic min_mem;
    } cand_flags_t;

endpackage

`default_nettype wire

FILE: hdl/swr_cell.sv
// one cell of the sample chain: a stored sample and its candidate flags
`default_nettype none

module swr_cell #(
    parameter int SAMPLE_BITS = swr_pkg::SAMPLE_BITS_DEF,
    parameter int WIN_BITS    = swr_pkg::CFG_BITS,
    parameter int CELL_IDX    = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          shift_en,
    input  wire logic                          flush,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic        [WIN_BITS-1:0]    win_eff,
    input  wire logic signed [SAMPLE_BITS-1:0] prev_value,
    input  wire swr_pkg::cand_flags_t          prev_flags,
    output logic signed      [SAMPLE_BITS-1:0] value,
    output swr_pkg::cand_flags_t               flags
);
    import swr_pkg::*;

    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    cand_flags_t                   flags_reg;
    cand_flags_t                   flags_next;
    logic                          in_window;

    // age of an entry equals its position in the chain
    assign in_window = WIN_BITS'(CELL_IDX) < win_eff;

    always_comb begin
        if (CELL_IDX == 0) begin
            // newest sample joins both lists
            value_next         = sample;
            flags_next.max_mem = 1'b1;
            flags_next.min_mem = 1'b1;
        end else begin
            value_next         = prev_value;
            flags_next.max_mem = prev_flags.max_mem & ~flush & in_window
                                 & (sample < prev_value);
            flags_next.min_mem = prev_flags.min_mem & ~flush & in_window
                                 & (sample > prev_value);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (shift_en) begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;
    assign flags = flags_reg;

endmodule

`default_nettype wire

FILE: hdl/swr_tree.sv
// registered selection tree: value of the highest-index marked leaf
`default_nettype none

module swr_tree #(
    parameter int LEAVES = swr_pkg::WINDOW_MAX_DEF,
    parameter int W      = swr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire logic signed [W-1:0] leaf_value [LEAVES],
    input  wire logic [LEAVES-1:0]   leaf_valid,
    output logic signed      [W-1:0] front_value,
    output logic                     front_valid
);
    localparam int LEVELS = $clog2(LEAVES);
    localparam int PADDED = 1 << LEVELS;

    logic signed [W-1:0] pad_value [PADDED];
    logic [PADDED-1:0]   pad_valid;
    logic signed [W-1:0] node_value_reg [1:LEVELS][PADDED];
    logic                node_valid_reg [1:LEVELS][PADDED];

    genvar gi, gl, gj;

    generate
        for (gi = 0; gi < PADDED; gi++) begin : g_pad
            if (gi < LEAVES) begin : g_leaf
                assign pad_value[gi] = leaf_value[gi];
                assign pad_valid[gi] = leaf_valid[gi];
            end else begin : g_fill
                assign pad_value[gi] = '0;
                assign pad_valid[gi] = 1'b0;
            end
        end

        for (gl = 1; gl <= LEVELS; gl++) begin : g_lvl
            for (gj = 0; gj < (PADDED >> gl); gj++) begin : g_node
                logic signed [W-1:0] lo_value;
                logic signed [W-1:0] hi_value;
                logic                lo_ok;
                logic                hi_ok;

                if (gl == 1) begin : g_first
                    assign lo_value = pad_value[2*gj];
                    assign hi_value = pad_value[2*gj+1];
                    assign lo_ok    = pad_valid[2*gj];
                    assign hi_ok    = pad_valid[2*gj+1];
                end else begin : g_inner
                    assign lo_value = node_value_reg[gl-1][2*gj];
                    assign hi_value = node_value_reg[gl-1][2*gj+1];
                    assign lo_ok    = node_valid_reg[gl-1][2*gj];
                    assign hi_ok    = node_valid_reg[gl-1][2*gj+1];
                end

                // older entries sit at higher index and win
                always_ff @(posedge aclk) begin
                    if (en) begin
                        node_value_reg[gl][gj] <= hi_ok ? hi_value : lo_value;
                        node_valid_reg[gl][gj] <= hi_ok | lo_ok;
                    end
                end
            end
        end
    endgenerate

    assign front_value = node_value_reg[LEVELS][0];
    assign front_valid = node_valid_reg[LEVELS][0];

endmodule

`default_nettype wire

FILE: hdl/sliding_window_range_unit.sv
// top level of the sliding window range unit (max minus min over a window)
`default_nettype none

// Takes one signed sample per clock and, once window_size samples of the current
// stream have arrived, returns max minus min over the latest window_size samples
// for every further sample. The samples live in a chain of WINDOW_MAX cells that
// shift by one position per accepted word, so a cell's position is the sample's
// age. Each cell keeps two flags saying whether its sample is still a maximum or
// a minimum candidate; flags drop when the sample ages out of the window or when
// a newer sample dominates it, and never come back. The oldest flagged cell of
// each list is found by a registered selection tree of log2(WINDOW_MAX) levels.
// Throughput is one word per cycle while no held result stalls the pipeline; the
// result of a word passes the cell registers, the tree levels and the output
// register. The whole pipeline advances together, so a held result with m_tready
// low stalls s_tready. A word with tlast set ends the stream and the next word
// starts empty. window_size 0 acts as 1, values above WINDOW_MAX act as
// WINDOW_MAX; a new size applies from the next word.

module sliding_window_range_unit #(
    parameter int WINDOW_MAX  = swr_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swr_pkg::SAMPLE_BITS_DEF,
    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // window size register
    input  wire logic                            cfg_wr_en,
    input  wire logic [swr_pkg::CFG_BITS-1:0]    cfg_wr_data,
    // sample words
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [S_TDATA_BITS-1:0]         s_tdata,   // sample
    input  wire logic                            s_tlast,   // last_in
    // result words
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [swr_pkg::RANGE_BITS-1:0]       m_tdata,   // range_value
    output logic                                 m_tlast    // last_out
);
    import swr_pkg::*;

    localparam int FILL_BITS = $clog2(WINDOW_MAX + 1);
    localparam int WIN_BITS  = (FILL_BITS > CFG_BITS) ? FILL_BITS : CFG_BITS;
    localparam int TREE_LAT  = $clog2(WINDOW_MAX);
    localparam int DIFF_BITS = (SAMPLE_BITS > RANGE_BITS) ? SAMPLE_BITS : RANGE_BITS;

    // configuration
    logic [CFG_BITS-1:0]   window_size_reg;
    logic [WIN_BITS-1:0]   win_wide;
    logic [WIN_BITS-1:0]   win_eff;

    // stream bookkeeping
    logic [FILL_BITS-1:0]  fill_count_reg;
    logic [FILL_BITS-1:0]  fill_base;
    logic [FILL_BITS-1:0]  fill_next;
    logic                  flush_reg;     // previous word closed the stream
    logic                  produce;

    // pipeline control
    logic                  en;
    logic                  accept;
    logic                  a_vld_reg;
    logic                  a_last_reg;
    logic                  pipe_vld_reg  [TREE_LAT];
    logic                  pipe_last_reg [TREE_LAT];

    // cell chain
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
    cand_flags_t                   cell_flags [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]         max_leaf;
    logic [WINDOW_MAX-1:0]         min_leaf;

    // list fronts
    logic signed [SAMPLE_BITS-1:0] max_front;
    logic signed [SAMPLE_BITS-1:0] min_front;
    logic                          max_front_vld;
    logic                          min_front_vld;
    logic [SAMPLE_BITS-1:0]        diff;
    logic [DIFF_BITS-1:0]          diff_ext;

    // output register
    logic                          m_tvalid_reg;
    logic [RANGE_BITS-1:0]         m_tdata_reg;
    logic                          m_tlast_reg;

    // everything moves when the output register is free or being drained
    assign en       = ~m_tvalid_reg | m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid & en;
    assign sample   = $signed(s_tdata[SAMPLE_BITS-1:0]);

    // window size clamped to 1..WINDOW_MAX
    assign win_wide = WIN_BITS'(window_size_reg);
    always_comb begin
        priority if (win_wide == '0) begin
            win_eff = WIN_BITS'(1);
        end else if (win_wide > WIN_BITS'(WINDOW_MAX)) begin
            win_eff = WIN_BITS'(WINDOW_MAX);
        end else begin
            win_eff = win_wide;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= CFG_BITS'(WINDOW_RESET);
        end else if (cfg_wr_en) begin
            window_size_reg <= cfg_wr_data;
        end
    end

    // fill count saturates at the chain length
    assign fill_base = flush_reg ? '0 : fill_count_reg;
    assign fill_next = (fill_base == FILL_BITS'(WINDOW_MAX)) ? fill_base
                                                              : fill_base + FILL_BITS'(1);
    assign produce   = WIN_BITS'(fill_next) >= win_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            flush_reg      <= 1'b0;
        end else if (accept) begin
            fill_count_reg <= fill_next;
            flush_reg      <= s_tlast;
        end
    end

    // chain of cells, newest sample in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            logic signed [SAMPLE_BITS-1:0] prev_value;
            cand_flags_t                   prev_flags;

            if (gi == 0) begin : g_head
                assign prev_value = sample;
                assign prev_flags = '0;
            end else begin : g_body
                assign prev_value = cell_value[gi-1];
                assign prev_flags = cell_flags[gi-1];
            end

            swr_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .WIN_BITS    (WIN_BITS),
                .CELL_IDX    (gi)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .shift_en   (accept),
                .flush      (flush_reg),
                .sample     (sample),
                .win_eff    (win_eff),
                .prev_value (prev_value),
                .prev_flags (prev_flags),
                .value      (cell_value[gi]),
                .flags      (cell_flags[gi])
            );

            assign max_leaf[gi] = cell_flags[gi].max_mem;
            assign min_leaf[gi] = cell_flags[gi].min_mem;
        end
    endgenerate

    // oldest candidate of each list is its front
    swr_tree #(
        .LEAVES (WINDOW_MAX),
        .W      (SAMPLE_BITS)
    ) u_max_tree (
        .aclk        (aclk),
        .en          (en),
        .leaf_value  (cell_value),
        .leaf_valid  (max_leaf),
        .front_value (max_front),
        .front_valid (max_front_vld)
    );

    swr_tree #(
        .LEAVES (WINDOW_MAX),
        .W      (SAMPLE_BITS)
    ) u_min_tree (
        .aclk        (aclk),
        .en          (en),
        .leaf_value  (cell_value),
        .leaf_valid  (min_leaf),
        .front_value (min_front),
        .front_valid (min_front_vld)
    );

    // result tags travel beside the tree levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            for (int k = 0; k < TREE_LAT; k++) begin
                pipe_vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            a_vld_reg       <= accept & produce;
            pipe_vld_reg[0] <= a_vld_reg;
            for (int k = 1; k < TREE_LAT; k++) begin
                pipe_vld_reg[k] <= pipe_vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_last_reg       <= s_tlast;
            pipe_last_reg[0] <= a_last_reg;
            for (int k = 1; k < TREE_LAT; k++) begin
                pipe_last_reg[k] <= pipe_last_reg[k-1];
            end
        end
    end

    // difference wraps at the sample width, then fits the 16-bit field
    assign diff     = $unsigned(max_front - min_front);
    assign diff_ext = DIFF_BITS'(diff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= pipe_vld_reg[TREE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= diff_ext[RANGE_BITS-1:0];
            m_tlast_reg <= pipe_last_reg[TREE_LAT-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // fill count never passes the chain length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= FILL_BITS'(WINDOW_MAX))
        else $error("fill count above chain length");

    // a new word always heads both lists
    a_head_member: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> cell_flags[0].max_mem && cell_flags[0].min_mem)
        else $error("newest sample missing from a list");

    // a result always finds both fronts
    a_front_found: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_vld_reg[TREE_LAT-1] |-> max_front_vld && min_front_vld)
        else $error("result without list front");

    // max front never below min front
    a_front_order: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_vld_reg[TREE_LAT-1] |-> max_front >= min_front)
        else $error("max front below min front");

    // first word after tlast starts a fresh stream
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && flush_reg |=> fill_count_reg == FILL_BITS'(1))
        else $error("stream not restarted after tlast");

endmodule

`default_nettype wire

FILE: verif/sliding_window_range_check.sv
// checker for the sliding window range unit: predicts each range word and compares results
`default_nettype none

module sliding_window_range_check (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [swr_pkg::CFG_BITS-1:0] cfg_wr_data,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [15:0]                  s_tdata,   // sample
    input  wire logic                         s_tlast,   // last_in
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [15:0]                  m_tdata,   // range_value
    input  wire logic                         m_tlast,   // last_out
    output int                                fail_count,
    output int                                pending
);

    localparam int DEPTH     = swr_pkg::WINDOW_MAX_DEF;
    localparam int HI_LIST   = 0;  // falling list, front is the maximum
    localparam int LO_LIST   = 1;  // rising list, front is the minimum
    localparam int SHOW_MAX  = 10;
    localparam int EXP_DEPTH = 64; // far above the words the pipeline can hold

    typedef struct packed {
        logic [swr_pkg::RANGE_BITS-1:0] range_value;
        logic                           last_out;
    } range_word_t;

    logic signed [15:0] cand_val [2][DEPTH];
    logic [6:0]         cand_age [2][DEPTH];
    int                 cand_len [2];
    int                 fill;
    logic [swr_pkg::CFG_BITS-1:0] win_reg;
    range_word_t        exp_ring [EXP_DEPTH];
    int                 exp_wr_idx;
    int                 exp_rd_idx;
    int                 exp_count;
    int                 mismatches;

    // age, expire at the front, drop dominated entries at the rear, append
    task shift_candidates(input int k, input logic signed [15:0] smp, input int w);
        int  i;
        int  drop;
        logic beaten;
        begin
            for (i = 0; i < cand_len[k]; i++)
                if (cand_age[k][i] < DEPTH)
                    cand_age[k][i] = cand_age[k][i] + 7'd1;
            drop = 0;
            while (drop < cand_len[k] && cand_age[k][drop] >= w)
                drop++;
            for (i = drop; i < cand_len[k]; i++) begin
                cand_val[k][i-drop] = cand_val[k][i];
                cand_age[k][i-drop] = cand_age[k][i];
            end
            cand_len[k] = cand_len[k] - drop;
            beaten = 1'b1;
            while (cand_len[k] > 0 && beaten) begin
                if (k == HI_LIST)
                    beaten = (smp >= cand_val[k][cand_len[k]-1]);
                else
                    beaten = (smp <= cand_val[k][cand_len[k]-1]);
                if (beaten)
                    cand_len[k] = cand_len[k] - 1;
            end
            if (cand_len[k] < DEPTH) begin
                cand_val[k][cand_len[k]] = smp;
                cand_age[k][cand_len[k]] = 7'd0;
                cand_len[k] = cand_len[k] + 1;
            end
        end
    endtask

    task clear_candidates;
        begin
            cand_len[HI_LIST] = 0;
            cand_len[LO_LIST] = 0;
            fill = 0;
        end
    endtask

    task predict_range(input logic [15:0] raw, input logic lst);
        int                 w;
        logic signed [16:0] diff;
        range_word_t        exp_word;
        begin
            w = (win_reg == 0) ? 1 : ((win_reg > DEPTH) ? DEPTH : int'(win_reg));
            shift_candidates(HI_LIST, $signed(raw), w);
            shift_candidates(LO_LIST, $signed(raw), w);
            if (fill < DEPTH)
                fill++;
            if (fill >= w) begin
                diff = cand_val[HI_LIST][0] - cand_val[LO_LIST][0];
                exp_word.range_value = diff[15:0];
                exp_word.last_out    = lst;
                exp_ring[exp_wr_idx] = exp_word;
                exp_wr_idx = (exp_wr_idx + 1) % EXP_DEPTH;
                exp_count++;
            end
            if (lst)
                clear_candidates();
        end
    endtask

    always @(posedge aclk) begin
        range_word_t exp_word;
        if (!aresetn) begin
            clear_candidates();
            win_reg = swr_pkg::WINDOW_RESET[swr_pkg::CFG_BITS-1:0];
            exp_wr_idx = 0;
            exp_rd_idx = 0;
            exp_count  = 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_range(s_tdata, s_tlast);
            if (cfg_wr_en)
                win_reg = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                if (exp_count == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("unexpected result word: range %0d last %0b",
                                 m_tdata, m_tlast);
                end else begin
                    exp_word   = exp_ring[exp_rd_idx];
                    exp_rd_idx = (exp_rd_idx + 1) % EXP_DEPTH;
                    exp_count--;
                    if (m_tdata !== exp_word.range_value || m_tlast !== exp_word.last_out) begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX)
                            $display("result mismatch: range exp %0d got %0d, last exp %0b got %0b",
                                     exp_word.range_value, m_tdata, exp_word.last_out, m_tlast);
                    end
                end
            end
        end
        pending    <= exp_count;
        fail_count <= mismatches;
    end

endmodule

`default_nettype wire

FILE: verif/sliding_window_range_unit_tb.sv
// testbench top for the sliding window range unit: stimulus, backpressure and verdict
`default_nettype none

module sliding_window_range_unit_tb;

    // slack below lets words that give no result leave the unit's pipeline
    localparam int DRAIN_SLACK  = 16;
    localparam int RANDOM_ITEMS = 1650;

    typedef enum int {PAT_RANDOM, PAT_NARROW, PAT_RISING, PAT_FALLING, PAT_EXTREME} pattern_e;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [swr_pkg::CFG_BITS-1:0] cfg_wr_data = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [15:0]                  s_tdata = '0;   // sample
    logic                         s_tlast = 1'b0; // last_in
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [15:0]                  m_tdata;        // range_value
    logic                         m_tlast;        // last_out

    int       fail_count;
    int       pending;
    int       items_sent = 0;
    int       burst_left = 0;
    logic     gaps_on = 1'b1;
    logic [7:0] rx_tick = '0;
    rx_mode_e rx_mode = RX_OPEN;

    // 10 unit clock period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sliding_window_range_unit uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    sliding_window_range_check checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: pick a new stall pattern each time the 8-bit tick counter wraps
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_tick == 8'd0)
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 7) != 0);
            default:   m_tready <= (rx_tick[3:0] >= 4'd6);
        endcase
    end

    // one sample word; bursts of random length separated by random gaps
    task send_word(input logic [15:0] smp, input logic lst);
        int gap;
        begin
            if (gaps_on && burst_left == 0) begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(1, 32);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= smp;
            s_tlast  <= lst;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            if (burst_left > 0)
                burst_left--;
            items_sent++;
        end
    endtask

    // hold off the sender until every predicted word has come back,
    // then let in-flight words that give no result leave the pipeline
    task wait_drained;
        begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (pending != 0) @(posedge aclk);
            repeat (DRAIN_SLACK) @(posedge aclk);
        end
    endtask

    // window register is only written with the unit idle
    task set_window(input logic [swr_pkg::CFG_BITS-1:0] w);
        begin
            wait_drained();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= w;
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
        end
    endtask

    function automatic logic [15:0] pattern_sample(pattern_e pat, int idx, logic [15:0] base);
        logic [15:0] v;
        case (pat)
            PAT_NARROW:  v = base + 16'($urandom_range(0, 3));
            PAT_RISING:  v = base + 16'(idx * 3);
            PAT_FALLING: v = base - 16'(idx * 5);
            PAT_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h8000;
                    1:       v = 16'h7fff;
                    2:       v = 16'h0000;
                    default: v = 16'hffff;
                endcase
            end
            default:     v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // timeout guard, many times the slowest legal run
    initial begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int          w_eff;
        int          len;
        int          i;
        int          pause_at;
        logic        close_it;
        logic [6:0]  w_pick;
        logic [15:0] base;
        pattern_e    pat;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset window of one, every word gives range zero
        send_word(16'h7fff, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hffff, 1'b1);

        // window of two across the extremes, full scale range
        set_window(7'd2);
        send_word(16'h7fff, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h7fff, 1'b1);

        // window size zero behaves as one
        set_window(7'd0);
        send_word(16'd5, 1'b0);
        send_word(-16'sd5, 1'b1);

        // oversize window saturates, stream ends before a full window
        set_window(7'd127);
        send_word(16'd1, 1'b0);
        send_word(16'd2, 1'b0);
        send_word(16'd3, 1'b1);

        // ties in both lists, stream left open
        set_window(7'd3);
        send_word(16'd1, 1'b0);
        send_word(16'd1, 1'b0);
        send_word(16'd1, 1'b0);
        send_word(16'd2, 1'b0);
        send_word(16'd0, 1'b0);

        // window grows mid-stream: results hold off until eight words are in
        set_window(7'd8);
        send_word(16'hfffe, 1'b0);
        send_word(16'd9, 1'b0);
        send_word(16'd4, 1'b0);
        send_word(16'h8001, 1'b1);

        // random phases, each a window setting followed by a run of words that may close the stream
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w_pick = 7'd0;
                1:       w_pick = 7'd127;
                2:       w_pick = 7'd64;
                3:       w_pick = 7'd1;
                9:       w_pick = 7'($urandom_range(0, 127));
                default: w_pick = 7'($urandom_range(2, 12));
            endcase
            set_window(w_pick);
            w_eff = (w_pick == 0) ? 1 : ((w_pick > 64) ? 64 : int'(w_pick));

            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(1, (w_eff > 1) ? w_eff - 1 : 1);
            else
                len = w_eff + $urandom_range(0, 60);
            close_it = ($urandom_range(0, 4) != 0);
            gaps_on  = ($urandom_range(0, 3) != 0);
            pat      = pattern_e'($urandom_range(0, 4));
            base     = 16'($urandom_range(0, 65535));
            pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;

            for (i = 0; i < len; i++) begin
                // sender stops until the result side has caught up
                if (i == pause_at)
                    wait_drained();
                send_word(pattern_sample(pat, i, base), close_it && (i == len - 1));
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/swr_pkg.sv
hdl/swr_cell.sv
hdl/swr_tree.sv
hdl/sliding_window_range_unit.sv
verif/sliding_window_range_check.sv
verif/sliding_window_range_unit_tb.sv
